/* rtl/pdmc_pkg.sv */
// Shared constants, types and codes of the distinct address counter.
package pdmc_pkg;

   localparam int DISTINCT_LIMIT = 4;
   localparam int WORD_W         = 64;
   localparam int PORT_W         = 9;
   localparam int OP_W           = 2;
   localparam int VERDICT_W      = 2;
   localparam int COUNT_W        = 3;
   localparam int CNT_W          = $clog2(DISTINCT_LIMIT + 1);
   localparam int COUNT_FIELD_MAX = 7;

   localparam logic [PORT_W-1:0] WATCHED_PORT_RESET = PORT_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_START = 2'd0,
      OP_ENTRY = 2'd1,
      OP_END   = 2'd2
   } op_type;

   localparam logic [VERDICT_W-1:0] VERDICT_NONE    = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_FOUND   = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_SWAPPED = 2'd2;

   typedef enum logic [1:0] {
      TOK_START  = 2'd0,
      TOK_INSERT = 2'd1,
      TOK_END    = 2'd2
   } tok_kind_type;

   // One item travelling down the row of cells. For an end item the word
   // field carries the first stored word and count the number of stored words.
   typedef struct packed {
      logic               valid;
      tok_kind_type       kind;
      logic [WORD_W-1:0]  word;
      logic [CNT_W-1:0]   count;
   } token_type;

endpackage

/* rtl/pdmc_if.sv */
// Channel interfaces of the distinct address counter.
interface pdmc_req_if;
   logic                          valid;
   logic                          ready;
   logic [pdmc_pkg::OP_W-1:0]     operation;
   logic [pdmc_pkg::WORD_W-1:0]   mac_vid;
   logic                          entry_valid;
   logic [pdmc_pkg::PORT_W-1:0]   entry_port;

   modport source (output valid, operation, mac_vid, entry_valid, entry_port, input ready);
   modport sink   (input valid, operation, mac_vid, entry_valid, entry_port, output ready);
endinterface

interface pdmc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pdmc_pkg::VERDICT_W-1:0] verdict;
   logic [pdmc_pkg::WORD_W-1:0]    first_entry;
   logic [pdmc_pkg::COUNT_W-1:0]   distinct_count;

   modport source (output valid, verdict, first_entry, distinct_count, input ready);
   modport sink   (input valid, verdict, first_entry, distinct_count, output ready);
endinterface

interface pdmc_csr_if;
   logic                         valid;
   logic                         ready;
   logic [pdmc_pkg::PORT_W-1:0]  watched_port;

   modport source (output valid, watched_port, input ready);
   modport sink   (input valid, watched_port, output ready);
endinterface

/* rtl/pdmc_cell.sv */
// One cell of the row: holds one stored word and passes items to the next cell.
module pdmc_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  pdmc_pkg::token_type tok_in,
   output pdmc_pkg::token_type tok_out,
   output logic                occupied
);
   import pdmc_pkg::*;

   token_type          tok_ff, tok_in_nx;
   logic               occupied_ff, occupied_in;
   logic [WORD_W-1:0]  word_ff, word_in;

   always_comb begin
      tok_in_nx   = tok_in;
      occupied_in = occupied_ff;
      word_in     = word_ff;
      if (tok_in.valid) begin
         case (tok_in.kind)
            TOK_START: begin
               occupied_in = 1'b0;
            end
            TOK_INSERT: begin
               // A match drops the item; the first free cell takes it.
               if (occupied_ff) begin
                  if (word_ff == tok_in.word) begin
                     tok_in_nx.valid = 1'b0;
                  end
               end else begin
                  occupied_in     = 1'b1;
                  word_in         = tok_in.word;
                  tok_in_nx.valid = 1'b0;
               end
            end
            TOK_END: begin
               if (occupied_ff) begin
                  if (tok_in.count == '0) begin
                     tok_in_nx.word = word_ff;
                  end
                  tok_in_nx.count = tok_in.count + CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         occupied_ff  <= 1'b0;
      end else if (en) begin
         tok_ff      <= tok_in_nx;
         occupied_ff <= occupied_in;
         word_ff     <= word_in;
      end
   end

   assign tok_out  = tok_ff;
   assign occupied = occupied_ff;

endmodule

/* rtl/port_distinct_mac_counter_top.sv */
// Distinct address counter for one watched switch port: top level.
// Every item moves through DISTINCT_LIMIT cells, one cell per cycle while the row
// advances, and an end item then moves into the result register.
// Throughput is one item per cycle; the row stalls only while an end item waits
// at the last cell and the result register still holds an untaken result.
// Synchronous reset empties all cells, drops items in flight, sets watched_port to 1.
module port_distinct_mac_counter_top (
   input  logic clock,
   input  logic reset,
   pdmc_req_if.sink   req,
   pdmc_rsp_if.source rsp,
   pdmc_csr_if.sink   csr
);
   import pdmc_pkg::*;

   logic [PORT_W-1:0]          watched_port_ff;
   token_type                  head_tok;
   token_type                  chain [DISTINCT_LIMIT];
   logic [DISTINCT_LIMIT-1:0]  occ;
   token_type                  tail_tok;
   logic                       tail_end;
   logic                       advance;

   logic                  rsp_valid_ff;
   logic [VERDICT_W-1:0]  verdict_ff, verdict_in;
   logic [WORD_W-1:0]     first_ff;
   logic [COUNT_W-1:0]    count_ff, count_in;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         watched_port_ff <= WATCHED_PORT_RESET;
      end else if (csr.valid) begin
         watched_port_ff <= csr.watched_port;
      end
   end

   // Entries that do not count become bubbles before entering the row.
   always_comb begin
      head_tok.valid = 1'b0;
      head_tok.kind  = TOK_START;
      head_tok.word  = req.mac_vid;
      head_tok.count = '0;
      if (req.valid) begin
         unique case (req.operation)
            OP_START: begin
               head_tok.valid = 1'b1;
               head_tok.kind  = TOK_START;
            end
            OP_ENTRY: begin
               head_tok.valid = req.entry_valid && (req.entry_port == watched_port_ff);
               head_tok.kind  = TOK_INSERT;
            end
            OP_END: begin
               head_tok.valid = 1'b1;
               head_tok.kind  = TOK_END;
               head_tok.word  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   for (genvar k = 0; k < DISTINCT_LIMIT; k++) begin : g_cell
      if (k == 0) begin : g_head
         pdmc_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .en       (advance),
            .tok_in   (head_tok),
            .tok_out  (chain[k]),
            .occupied (occ[k])
         );
      end else begin : g_body
         pdmc_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .en       (advance),
            .tok_in   (chain[k-1]),
            .tok_out  (chain[k]),
            .occupied (occ[k])
         );
      end
   end

   assign tail_tok  = chain[DISTINCT_LIMIT-1];
   assign tail_end  = tail_tok.valid && (tail_tok.kind == TOK_END);
   assign advance   = !(tail_end && rsp_valid_ff && !rsp.ready);
   assign req.ready = advance;

   always_comb begin
      if (32'(tail_tok.count) >= DISTINCT_LIMIT) begin
         verdict_in = VERDICT_SWAPPED;
      end else if (tail_tok.count != '0) begin
         verdict_in = VERDICT_FOUND;
      end else begin
         verdict_in = VERDICT_NONE;
      end
      if (32'(tail_tok.count) > COUNT_FIELD_MAX) begin
         count_in = COUNT_W'(COUNT_FIELD_MAX);
      end else begin
         count_in = COUNT_W'(tail_tok.count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && tail_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tail_end) begin
         verdict_ff <= verdict_in;
         first_ff   <= tail_tok.word;
         count_ff   <= count_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.verdict        = verdict_ff;
   assign rsp.first_entry    = first_ff;
   assign rsp.distinct_count = count_ff;

   // An insert item only leaves a cell that already holds a different word.
   for (genvar k = 0; k < DISTINCT_LIMIT; k++) begin : g_chk
      a_pass_full: assert property (@(posedge clock) disable iff (reset)
         (chain[k].valid && chain[k].kind == TOK_INSERT) |-> occ[k])
         else $error("insert item passed an empty cell");
   end

   a_none_empty: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ((rsp.verdict == VERDICT_NONE) == (rsp.distinct_count == '0)))
      else $error("verdict disagrees with distinct count");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.verdict == VERDICT_NONE) |-> (rsp.first_entry == '0))
      else $error("empty verdict carries a nonzero word");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (tail_end && rsp.valid))
      else $error("row stalled without a waiting end item");

endmodule
